@@ src/xted_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and entity tables for the xml text entity decoder
package xted_pkg;

	localparam int HOLD_DEPTH_DEF = 6;

	// named references, without the leading ampersand
	localparam int ENT_COUNT = 6;
	localparam int NAME_MAX = 5;
	localparam logic [7:0] ENT_NAME [ENT_COUNT][NAME_MAX] = '{
		'{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},	// lt;
		'{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},	// gt;
		'{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},	// amp;
		'{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},	// apos;
		'{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},	// quot;
		'{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}	// nbsp;
	};
	localparam int ENT_LEN [ENT_COUNT] = '{3, 3, 4, 5, 5, 5};
	localparam logic [7:0] ENT_CHAR [ENT_COUNT] = '{
		8'h3C, 8'h3E, 8'h26, 8'h27, 8'h22, 8'h20
	};

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_F = 8'h66;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_F = 8'h46;

	localparam int CP_W = 17;
	localparam logic [CP_W-1:0] CP_SAT     = 17'h10000;
	localparam logic [CP_W-1:0] CP_2B_MIN  = 17'h00080;
	localparam logic [CP_W-1:0] CP_3B_MIN  = 17'h00800;
	localparam logic [7:0]      UTF_LEAD2  = 8'hC0;
	localparam logic [7:0]      UTF_LEAD3  = 8'hE0;
	localparam logic [7:0]      UTF_CONT   = 8'h80;

	localparam int CFG_ADDR_W = 3;
	localparam logic REG_IDX_STOP = 1'b0;
	localparam logic STOP_RESET = 1'b1;

	typedef enum logic [1:0] {PH_PLAIN, PH_NAMED, PH_HASH, PH_NUM} phase_t;
	typedef enum logic [1:0] {CPC_1, CPC_2, CPC_3, CPC_NONE} cp_class_t;
	typedef enum logic [1:0] {CP_KEEP, CP_ZERO, CP_DIGIT, CP_ACC} cp_op_t;

	typedef enum logic [3:0] {
		OS_AMP, OS_HASH, OS_HELD, OS_U2, OS_U1, OS_U0, OS_BYTE, OS_END, OS_ENT
	} out_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_AMP, ST_HASHC, ST_HELD, ST_U2, ST_U1, ST_U0, ST_BYTE, ST_END, ST_ENT
	} state_t;

	typedef struct packed {
		logic      sel_in;
		logic      accept;
		logic      phase_we;
		phase_t    phase_nx;
		logic      held_push;
		logic      held_clr;
		logic      rep_clr;
		logic      rep_inc;
		cp_op_t    cp_op;
		logic      hex_we;
		logic      hex_nx;
		logic      out_load;
		out_sel_t  out_sel;
		logic      out_last;
	} dp_cmd_t;

	typedef struct packed {
		phase_t    phase;
		logic      eot;
		logic      is_amp;
		logic      is_hash;
		logic      is_x;
		logic      dec_dig;
		logic      num_dig;
		logic      name_full;
		logic      name_prefix;
		logic      held_zero;
		logic      rep_last;
		logic      out_free;
		cp_class_t cp_cls;
	} dp_status_t;

endpackage

@@ src/xted_dp.sv @@
`timescale 1ns / 1ps
// datapath: reference state, name matcher, code point accumulator, output register
module xted_dp #(
	parameter int HOLD_DEPTH = xted_pkg::HOLD_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  xted_pkg::dp_cmd_t   cmd,
	output xted_pkg::dp_status_t st,
	input  logic [7:0]          in_byte,
	input  logic                end_of_text,
	input  logic                stop_on_lt,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                run_end,
	output logic                last
);
	import xted_pkg::*;

	localparam int IDX_W = $clog2(HOLD_DEPTH);
	localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
	localparam int ACC_W = CP_W + 4;

	phase_t            phase_q;
	logic [7:0]        held_q [HOLD_DEPTH];
	logic [CNT_W-1:0]  held_cnt_q;
	logic [IDX_W-1:0]  rep_q;
	logic [CP_W-1:0]   cp_q;
	logic              hex_q;
	logic [7:0]        byte_q;
	logic              eot_q;
	logic [7:0]        ent_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              run_end_q;
	logic              last_q;

	logic [7:0]        cur_byte;
	logic              cur_eot;
	logic              is_dec;
	logic              is_hex_alpha;
	logic [3:0]        dig_val;
	logic              name_full;
	logic              name_prefix;
	logic [7:0]        ent_char;
	logic [ACC_W-1:0]  acc_w;
	logic [CP_W-1:0]   cp_next;
	cp_class_t         cp_cls;
	logic [7:0]        nx_byte;
	logic              nx_end;
	logic              out_free;

	assign cur_byte = cmd.sel_in ? in_byte : byte_q;
	assign cur_eot  = cmd.sel_in ? end_of_text : eot_q;

	assign is_dec       = (cur_byte >= CH_0) && (cur_byte <= CH_9);
	assign is_hex_alpha = ((cur_byte >= CH_LO_A) && (cur_byte <= CH_LO_F)) ||
		((cur_byte >= CH_UP_A) && (cur_byte <= CH_UP_F));
	// letters a-f and A-F both have low nibble 1..6
	assign dig_val = is_dec ? cur_byte[3:0] : cur_byte[3:0] + 4'd9;

	// candidate = held bytes followed by the current byte
	always_comb begin
		logic hit;
		name_full   = 1'b0;
		name_prefix = 1'b0;
		ent_char    = 8'h00;
		hit         = 1'b0;
		for (int k = 0; k < ENT_COUNT; k++) begin
			hit = (int'(held_cnt_q) + 1 <= ENT_LEN[k]);
			for (int j = 0; j < NAME_MAX; j++) begin
				if (CNT_W'(j) < held_cnt_q)
					hit = hit && (held_q[j] == ENT_NAME[k][j]);
				else if (CNT_W'(j) == held_cnt_q)
					hit = hit && (cur_byte == ENT_NAME[k][j]);
			end
			if (hit) begin
				if (int'(held_cnt_q) + 1 == ENT_LEN[k]) begin
					name_full = 1'b1;
					ent_char  = ENT_CHAR[k];
				end else begin
					name_prefix = 1'b1;
				end
			end
		end
	end

	// saturating accumulate, times 16 or times 10
	always_comb begin
		if (hex_q)
			acc_w = {cp_q, 4'b0000};
		else
			acc_w = ({4'b0000, cp_q} << 3) + ({4'b0000, cp_q} << 1);
		acc_w = acc_w + {{(ACC_W-4){1'b0}}, dig_val};
		if (acc_w >= {4'b0000, CP_SAT})
			cp_next = CP_SAT;
		else
			cp_next = acc_w[CP_W-1:0];
	end

	always_comb begin
		if (cp_q < CP_2B_MIN)
			cp_cls = CPC_1;
		else if (cp_q < CP_3B_MIN)
			cp_cls = CPC_2;
		else if (cp_q < CP_SAT)
			cp_cls = CPC_3;
		else
			cp_cls = CPC_NONE;
	end

	always_comb begin
		nx_byte = 8'h00;
		nx_end  = 1'b0;
		case (cmd.out_sel)
			OS_AMP:  nx_byte = CH_AMP;
			OS_HASH: nx_byte = CH_HASH;
			OS_HELD: nx_byte = held_q[rep_q];
			OS_U2:   nx_byte = UTF_LEAD3 + {4'b0000, cp_q[15:12]};
			OS_U1: begin
				if (cp_cls == CPC_2)
					nx_byte = UTF_LEAD2 + {3'b000, cp_q[10:6]};
				else
					nx_byte = UTF_CONT + {2'b00, cp_q[11:6]};
			end
			OS_U0: begin
				if (cp_cls == CPC_1)
					nx_byte = cp_q[7:0];
				else
					nx_byte = UTF_CONT + {2'b00, cp_q[5:0]};
			end
			OS_BYTE: begin
				if (stop_on_lt && (byte_q == CH_LT))
					nx_end = 1'b1;
				else
					nx_byte = byte_q;
			end
			OS_END:  nx_end = 1'b1;
			OS_ENT:  nx_byte = ent_q;
			default: nx_byte = 8'h00;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st.phase       = phase_q;
		st.eot         = cur_eot;
		st.is_amp      = (cur_byte == CH_AMP);
		st.is_hash     = (cur_byte == CH_HASH);
		st.is_x        = (cur_byte == CH_X);
		st.dec_dig     = is_dec;
		st.num_dig     = is_dec || (hex_q && is_hex_alpha);
		st.name_full   = name_full;
		st.name_prefix = name_prefix;
		st.held_zero   = (held_cnt_q == '0);
		st.rep_last    = (CNT_W'(rep_q) + CNT_W'(1) == held_cnt_q);
		st.out_free    = out_free;
		st.cp_cls      = cp_cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PLAIN;
			held_cnt_q  <= '0;
			rep_q       <= '0;
			cp_q        <= '0;
			hex_q       <= 1'b0;
			eot_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept)
				eot_q <= end_of_text;
			if (cmd.phase_we)
				phase_q <= cmd.phase_nx;
			if (cmd.held_clr)
				held_cnt_q <= '0;
			else if (cmd.held_push)
				held_cnt_q <= held_cnt_q + CNT_W'(1);
			if (cmd.rep_clr)
				rep_q <= '0;
			else if (cmd.rep_inc)
				rep_q <= rep_q + IDX_W'(1);
			case (cmd.cp_op)
				CP_KEEP:  cp_q <= cp_q;
				CP_ZERO:  cp_q <= '0;
				CP_DIGIT: cp_q <= {{(CP_W-4){1'b0}}, dig_val};
				CP_ACC:   cp_q <= cp_next;
				default:  cp_q <= cp_q;
			endcase
			if (cmd.hex_we)
				hex_q <= cmd.hex_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_byte;
			ent_q  <= ent_char;
		end
		if (cmd.held_push)
			held_q[held_cnt_q[IDX_W-1:0]] <= cur_byte;
		if (cmd.out_load) begin
			out_byte_q <= nx_byte;
			run_end_q  <= nx_end;
			last_q     <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	// a held name never grows past the longest proper prefix
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(held_cnt_q) < NAME_MAX)
		else $error("held byte count out of range");

	a_cp_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cp_q <= CP_SAT)
		else $error("code point above saturation value");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");

	a_replay_named: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_sel == OS_HELD) |->
		(phase_q == PH_NAMED && CNT_W'(rep_q) < held_cnt_q))
		else $error("held byte replay outside a pending name");
`endif

endmodule

@@ src/xted_ctrl.sv @@
`timescale 1ns / 1ps
// controller: per-byte decision and result sequencing for the decoder
module xted_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output xted_pkg::dp_cmd_t    cmd,
	input  xted_pkg::dp_status_t st
);
	import xted_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.phase_nx = PH_PLAIN;
		cmd.cp_op    = CP_KEEP;
		cmd.out_sel  = OS_BYTE;
		cmd.sel_in   = (state_q == ST_IDLE);
		state_nx     = state_q;
		tail         = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept  = 1'b1;
					cmd.rep_clr = 1'b1;
					if (st.eot) begin
						case (st.phase)
							PH_PLAIN: state_nx = ST_END;
							PH_NAMED: state_nx = ST_AMP;
							PH_HASH:  state_nx = ST_AMP;
							PH_NUM: begin
								case (st.cp_cls)
									CPC_1:   state_nx = ST_U0;
									CPC_2:   state_nx = ST_U1;
									CPC_3:   state_nx = ST_U2;
									default: state_nx = ST_END;
								endcase
							end
							default: state_nx = ST_END;
						endcase
					end else begin
						case (st.phase)
							PH_PLAIN: begin
								if (st.is_amp) begin
									cmd.phase_we = 1'b1;
									cmd.phase_nx = PH_NAMED;
									cmd.held_clr = 1'b1;
								end else begin
									state_nx = ST_BYTE;
								end
							end
							PH_NAMED: begin
								if (st.held_zero && st.is_hash) begin
									cmd.phase_we = 1'b1;
									cmd.phase_nx = PH_HASH;
								end else if (st.name_full) begin
									state_nx = ST_ENT;
								end else if (st.name_prefix) begin
									cmd.held_push = 1'b1;
								end else begin
									state_nx = ST_AMP;
								end
							end
							PH_HASH: begin
								if (st.is_x) begin
									cmd.phase_we = 1'b1;
									cmd.phase_nx = PH_NUM;
									cmd.hex_we   = 1'b1;
									cmd.hex_nx   = 1'b1;
									cmd.cp_op    = CP_ZERO;
								end else if (st.dec_dig) begin
									cmd.phase_we = 1'b1;
									cmd.phase_nx = PH_NUM;
									cmd.hex_we   = 1'b1;
									cmd.hex_nx   = 1'b0;
									cmd.cp_op    = CP_DIGIT;
								end else begin
									state_nx = ST_AMP;
								end
							end
							PH_NUM: begin
								if (st.num_dig) begin
									cmd.cp_op = CP_ACC;
								end else begin
									// terminator is swallowed
									case (st.cp_cls)
										CPC_1: state_nx = ST_U0;
										CPC_2: state_nx = ST_U1;
										CPC_3: state_nx = ST_U2;
										default: begin
											cmd.phase_we = 1'b1;
											cmd.phase_nx = PH_PLAIN;
										end
									endcase
								end
							end
							default: state_nx = ST_IDLE;
						endcase
					end
				end
			end
			ST_AMP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OS_AMP;
					if (st.phase == PH_HASH)
						state_nx = ST_HASHC;
					else if (!st.held_zero)
						state_nx = ST_HELD;
					else
						tail = 1'b1;
				end
			end
			ST_HASHC: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OS_HASH;
					tail         = 1'b1;
				end
			end
			ST_HELD: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OS_HELD;
					cmd.rep_inc  = 1'b1;
					if (st.rep_last)
						tail = 1'b1;
				end
			end
			ST_U2: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OS_U2;
					state_nx     = ST_U1;
				end
			end
			ST_U1: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OS_U1;
					state_nx     = ST_U0;
				end
			end
			ST_U0: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OS_U0;
					if (st.eot) begin
						state_nx = ST_END;
					end else begin
						cmd.phase_we = 1'b1;
						cmd.phase_nx = PH_PLAIN;
						cmd.out_last = 1'b1;
						state_nx     = ST_IDLE;
					end
				end
			end
			ST_BYTE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OS_BYTE;
					cmd.out_last = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			ST_END, ST_ENT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = (state_q == ST_END) ? OS_END : OS_ENT;
					cmd.out_last = 1'b1;
					cmd.phase_we = 1'b1;
					cmd.phase_nx = PH_PLAIN;
					cmd.held_clr = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase

		// after a flushed reference: treat the latched byte as plain text
		if (tail) begin
			if (st.eot) begin
				state_nx = ST_END;
			end else if (st.is_amp) begin
				cmd.phase_we = 1'b1;
				cmd.phase_nx = PH_NAMED;
				cmd.held_clr = 1'b1;
				cmd.out_last = 1'b1;
				state_nx     = ST_IDLE;
			end else begin
				cmd.phase_we = 1'b1;
				cmd.phase_nx = PH_PLAIN;
				cmd.held_clr = 1'b1;
				state_nx     = ST_BYTE;
			end
		end
	end

endmodule

@@ src/xml_text_entity_decoder_unit.sv @@
`timescale 1ns / 1ps
// top level: xml text entity decoder with utf-8 output and apb register port
//
// Decodes XML text one byte per input transfer into output bytes: named
// references (lt, gt, amp, apos, quot, nbsp) become one byte, numeric
// references (&#x hex or &# decimal) below 0x10000 become 1 to 3 UTF-8
// bytes, and a run_end result marks a literal '<' (when stop_on_less_than
// is set, its reset value) or end of text. A byte that only advances a
// pending reference yields no result. The most results come from a failed
// four-letter name replayed with its breaking byte or a flushed name at
// end of text. The sequencer loads the single output register with one
// result per cycle while the output is not stalled, and further input
// waits. Register stop_on_less_than sits at byte address 0; the user must
// write it only while the block is idle, as the block does not enforce it.
module xml_text_entity_decoder_unit #(
	parameter int HOLD_DEPTH = xted_pkg::HOLD_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      in_byte,
	input  logic                            end_of_text,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_byte,
	output logic                            run_end,
	output logic                            last,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [xted_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import xted_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;
	logic       stop_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stop_q <= STOP_RESET;
		else if (psel && penable && pwrite && (paddr[2] == REG_IDX_STOP))
			stop_q <= pwdata[0];
	end

	assign prdata = (paddr[2] == REG_IDX_STOP) ? {31'b0, stop_q} : 32'b0;

	xted_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st)
	);

	xted_dp #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.stop_on_lt  (stop_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_end     (run_end),
		.last        (last)
	);

endmodule
